/* rtl/core/sbe_pkg.sv */
// Shared types, widths, band table and rounding helper for the STFT band-energy block.
// Depends on nothing; used by stft_band_energy only.
package sbe_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int WORK_W     = 28;                    // real or imaginary part of one bin
  localparam int WIN_W      = 16;                    // Q1.15 window, never negative
  localparam int TW_W       = 17;                    // twiddle at 2^15 scale
  localparam int PROD_W     = WORK_W + TW_W;         // one multiplier product
  localparam int ACC_W      = PROD_W + 1;            // sum or difference of two products
  localparam int SQ_W       = 2 * WORK_W;            // one squared part
  localparam int SQRT_IN_W  = SQ_W + 2;              // sum of squares, padded to even width
  localparam int ROOT_W     = SQRT_IN_W / 2;
  localparam int ENERGY_W   = 28;
  localparam int BAND_W     = 5;
  localparam int FRAME_W    = 7;
  localparam int COUNT_W    = 16;
  localparam int TABLE_BANDS = 24;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

  // Taylor term divisors for cosine, (2k-1)(2k), and sine, (2k)(2k+1)
  localparam longint unsigned TAYLOR_COS_DIV [8] = '{2, 12, 30, 56, 90, 132, 182, 240};
  localparam longint unsigned TAYLOR_SIN_DIV [8] = '{6, 20, 42, 72, 110, 156, 210, 272};

  localparam logic [7:0] BAND_LO [TABLE_BANDS] = '{
    8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd8, 8'd10, 8'd12, 8'd15, 8'd18, 8'd22,
    8'd26, 8'd32, 8'd39, 8'd47, 8'd57, 8'd69, 8'd83, 8'd100, 8'd120, 8'd144, 8'd172, 8'd206};
  localparam logic [7:0] BAND_HI [TABLE_BANDS] = '{
    8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd7, 8'd9, 8'd11, 8'd14, 8'd17, 8'd21, 8'd25,
    8'd31, 8'd38, 8'd46, 8'd56, 8'd68, 8'd82, 8'd99, 8'd119, 8'd143, 8'd171, 8'd205, 8'd240};

  typedef struct packed {
    logic signed [WORK_W-1:0] re;
    logic signed [WORK_W-1:0] im;
  } cplx_t;

  // round a 2^15-scaled value to nearest, ties away from zero
  function automatic logic signed [ACC_W-1:0] rnd_q15(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] mag;
    mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    mag = (mag + (ACC_W'(1) << 14)) >> 15;
    return v[ACC_W-1] ? $signed(ACC_W'(-mag)) : $signed(mag);
  endfunction

endpackage

/* rtl/core/sbe_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module sbe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/sbe_isqrt.sv */
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on nothing but its parameter; used by the band-energy top level.
module sbe_isqrt #(
  parameter int IN_W = 58
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [IN_W-1:0]   operand_i,
  output logic              done_o,
  output logic [IN_W/2-1:0] root_o
);

  localparam int RW    = IN_W / 2;
  localparam int RM_W  = RW + 3;
  localparam int CNT_W = $clog2(RW + 1);

  logic             busy_q, busy_d, done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IN_W-1:0]  opd_q, opd_d;
  logic [RM_W-1:0]  rem_q, rem_d, rem_sh, trial;
  logic [RW-1:0]    root_q, root_d;
  logic             ge;

  always_comb begin
    rem_sh = {rem_q[RM_W-3:0], opd_q[IN_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    ge     = rem_sh >= trial;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    opd_d  = opd_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(RW - 1);
      opd_d  = operand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      opd_d  = opd_q << 2;
      rem_d  = ge ? rem_sh - trial : rem_sh;
      root_d = {root_q[RW-2:0], ge};
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    opd_q  <= opd_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* rtl/core/stft_band_energy.sv */
// Short-time spectral band energies of a 16-bit audio stream.
// Depends on sbe_pkg, sbe_ram and sbe_isqrt.
//
// The block takes one sample per input transfer, in blocks that block_start_i restarts.
// Once FFT_SIZE samples of a block have arrived, and then every HOP_SIZE samples up to
// BLOCK_SAMPLES, it weights the latest FFT_SIZE samples by a symmetric Q1.15 Hann window,
// runs an unscaled radix-2 DFT in place in a work RAM, and emits one output transfer per
// band (24 by default) holding the floor-sqrt bin magnitudes summed over the band,
// saturating at 2^28-1. A sample that does not complete a frame causes no hold-off. A
// sample that completes a frame holds off input until the last band has been handed to
// the output register, while the block windows and loads the frame, runs the
// (N/2)*log2(N) butterflies through the shared complex-part multiplier, takes the bin
// magnitudes below N/2 with the bit-serial square root and hands each band to the output
// register, waiting while the output is stalled. With N = 256 only bins 1 to 127 enter a
// band sum.
// The output register lets the next samples in while the last band still waits.
module stft_band_energy #(
  parameter int FFT_SIZE      = 256,
  parameter int HOP_SIZE      = 128,
  parameter int BLOCK_SAMPLES = 16000,
  parameter int BAND_COUNT    = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [sbe_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                                 block_start_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [sbe_pkg::BAND_W-1:0]           band_index_o,
  output logic [sbe_pkg::FRAME_W-1:0]          frame_index_o,
  output logic [sbe_pkg::ENERGY_W-1:0]         band_energy_o,
  output logic                                 last_band_o
);

  localparam int LOGN    = $clog2(FFT_SIZE);
  localparam int HALF    = FFT_SIZE / 2;
  localparam int WIN_DEN = FFT_SIZE - 1;
  localparam int NB      = BAND_COUNT < sbe_pkg::TABLE_BANDS ? BAND_COUNT
                                                              : sbe_pkg::TABLE_BANDS;
  localparam int PH_W    = HOP_SIZE > 1 ? $clog2(HOP_SIZE) : 1;
  localparam int STG_W   = $clog2(LOGN);
  localparam int BIN_W   = LOGN > 8 ? LOGN : 8;
  localparam int WIN_W   = sbe_pkg::WIN_W;
  localparam int TW_W    = sbe_pkg::TW_W;
  localparam int WORK_W  = sbe_pkg::WORK_W;
  localparam int ACC_W   = sbe_pkg::ACC_W;
  localparam int PROD_W  = sbe_pkg::PROD_W;
  localparam int COUNT_W = sbe_pkg::COUNT_W;

  // ---------------------------------------------------------------------------
  // Constant tables, built at elaboration from the Q30 Taylor-series cos/sin
  // ---------------------------------------------------------------------------
  function automatic longint cs_q30(input int unsigned num, input bit on_win,
                                    input bit want_sin);
    longint unsigned m, r, x, x2, tc, ts;
    longint          vc, vs, c, s;
    int unsigned     q, nr;
    if (on_win) begin
      nr = num % WIN_DEN;
      m  = 4 * longint'(nr);
      q  = int'(m / WIN_DEN);
      r  = m % WIN_DEN;
      x  = sbe_pkg::Q30_HALF_PI * r / WIN_DEN;
    end else begin
      nr = num % FFT_SIZE;
      m  = 4 * longint'(nr);
      q  = int'(m / FFT_SIZE);
      r  = m % FFT_SIZE;
      x  = sbe_pkg::Q30_HALF_PI * r / FFT_SIZE;
    end
    x2 = (x * x) >> 30;
    tc = sbe_pkg::Q30_ONE;
    vc = longint'(sbe_pkg::Q30_ONE);
    ts = x;
    vs = longint'(x);
    for (int k = 0; k < 8; k++) begin
      tc = ((tc * x2) >> 30) / sbe_pkg::TAYLOR_COS_DIV[k];
      ts = ((ts * x2) >> 30) / sbe_pkg::TAYLOR_SIN_DIV[k];
      if ((k % 2) == 0) begin
        vc = vc - longint'(tc);
        vs = vs - longint'(ts);
      end else begin
        vc = vc + longint'(tc);
        vs = vs + longint'(ts);
      end
    end
    if (vc < 0) vc = 0;
    if (vc > longint'(sbe_pkg::Q30_ONE)) vc = longint'(sbe_pkg::Q30_ONE);
    if (vs < 0) vs = 0;
    if (vs > longint'(sbe_pkg::Q30_ONE)) vs = longint'(sbe_pkg::Q30_ONE);
    case (q % 4)
      0:       begin c = vc;  s = vs;  end
      1:       begin c = -vs; s = vc;  end
      2:       begin c = -vc; s = -vs; end
      default: begin c = vs;  s = -vc; end
    endcase
    return want_sin ? s : c;
  endfunction

  function automatic logic [FFT_SIZE*WIN_W-1:0] build_win();
    logic [FFT_SIZE*WIN_W-1:0] rom;
    longint                    w;
    rom = '0;
    for (int i = 0; i < FFT_SIZE; i++) begin
      w = (longint'(sbe_pkg::Q30_ONE) - cs_q30(i, 1'b1, 1'b0) + 32768) >>> 16;
      if (w > 32767) w = 32767;
      rom[i*WIN_W +: WIN_W] = WIN_W'(w);
    end
    return rom;
  endfunction

  function automatic logic [HALF*TW_W-1:0] build_tw(input bit want_sin);
    logic [HALF*TW_W-1:0] rom;
    longint               v, mag;
    rom = '0;
    for (int i = 0; i < HALF; i++) begin
      v   = cs_q30(i, 1'b0, want_sin);
      mag = ((v < 0 ? -v : v) + 16384) >>> 15;
      rom[i*TW_W +: TW_W] = TW_W'(v < 0 ? -mag : mag);
    end
    return rom;
  endfunction

  function automatic logic [LOGN-1:0] bit_rev(input logic [LOGN-1:0] v);
    logic [LOGN-1:0] r;
    for (int i = 0; i < LOGN; i++) begin
      r[i] = v[LOGN-1-i];
    end
    return r;
  endfunction

  localparam logic [FFT_SIZE*WIN_W-1:0] WIN_ROM = build_win();
  localparam logic [HALF*TW_W-1:0]      COS_ROM = build_tw(1'b0);
  localparam logic [HALF*TW_W-1:0]      SIN_ROM = build_tw(1'b1);

  // ---------------------------------------------------------------------------
  // Sequencer states
  // ---------------------------------------------------------------------------
  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_LD_RD   = 5'd1;
  localparam logic [4:0] ST_LD_MUL  = 5'd2;
  localparam logic [4:0] ST_LD_WR   = 5'd3;
  localparam logic [4:0] ST_BF_RDA  = 5'd4;
  localparam logic [4:0] ST_BF_RDB  = 5'd5;
  localparam logic [4:0] ST_BF_M0   = 5'd6;
  localparam logic [4:0] ST_BF_M1   = 5'd7;
  localparam logic [4:0] ST_BF_M2   = 5'd8;
  localparam logic [4:0] ST_BF_M3   = 5'd9;
  localparam logic [4:0] ST_BF_M4   = 5'd10;
  localparam logic [4:0] ST_BF_M5   = 5'd11;
  localparam logic [4:0] ST_BF_WA   = 5'd12;
  localparam logic [4:0] ST_BF_WB   = 5'd13;
  localparam logic [4:0] ST_BD_INIT = 5'd14;
  localparam logic [4:0] ST_BD_RD   = 5'd15;
  localparam logic [4:0] ST_BD_CAP  = 5'd16;
  localparam logic [4:0] ST_BD_SQ2  = 5'd17;
  localparam logic [4:0] ST_BD_ROOT = 5'd18;
  localparam logic [4:0] ST_BD_WAIT = 5'd19;
  localparam logic [4:0] ST_EMIT    = 5'd20;

  logic [4:0]                 state_q, state_d;
  logic [COUNT_W-1:0]         cnt_q, cnt_d;
  logic [sbe_pkg::FRAME_W-1:0] frm_q, frm_d;
  logic [PH_W-1:0]            ph_q, ph_d;
  logic [LOGN-1:0]            base_q, base_d;
  logic [LOGN-1:0]            n_q, n_d;
  logic [STG_W-1:0]           stg_q, stg_d;
  logic [LOGN-2:0]            bf_q, bf_d;
  logic [sbe_pkg::BAND_W-1:0] band_q, band_d;
  logic [BIN_W-1:0]           k_q, k_d, kend_q, kend_d;
  logic [sbe_pkg::ENERGY_W-1:0] acc_q, acc_d;

  sbe_pkg::cplx_t             a_q, a_d, b_q, b_d;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic signed [ACC_W-1:0]    sum_q, sum_d, diff_q, diff_d;
  logic signed [WORK_W-1:0]   tr_q, tr_d, ti_q, ti_d;
  logic [sbe_pkg::SQ_W-1:0]   sqa_q, sqa_d, sqb_q, sqb_d;

  logic                         out_vld_q, out_vld_d;
  logic [sbe_pkg::BAND_W-1:0]   oband_q, oband_d;
  logic [sbe_pkg::FRAME_W-1:0]  ofrm_q, ofrm_d;
  logic [sbe_pkg::ENERGY_W-1:0] oeng_q, oeng_d;
  logic                         olast_q, olast_d;

  // input side
  logic               in_acc;
  logic [COUNT_W-1:0] cnt_cur, cnt_new;
  logic [PH_W-1:0]    ph_new;
  logic               fire;

  // memories
  logic                          smp_we;
  logic [LOGN-1:0]               smp_raddr;
  logic [sbe_pkg::SAMPLE_W-1:0]  smp_rdata;
  logic                          wrk_we;
  logic [LOGN-1:0]               wrk_waddr, wrk_raddr;
  sbe_pkg::cplx_t                wrk_wdata, wrk_rdata;

  // butterfly addressing
  logic [LOGN-2:0]           jmask, jpart;
  logic [LOGN-1:0]           ia, ib;
  logic [STG_W-1:0]          tw_sh;
  logic [LOGN-2:0]           tw_idx;
  logic signed [TW_W-1:0]    wr, wi;

  // shared multipliers
  logic signed [WORK_W-1:0]  mul_a, sq_op;
  logic signed [TW_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [sbe_pkg::SQ_W-1:0] sq_p;

  // band bookkeeping
  logic [BIN_W-1:0]          lo_bin, hi_bin, hi_cap;
  logic [WIN_W-1:0]          win_n;
  logic signed [ACC_W-1:0]   rnd_out;
  logic                      sqrt_start, sqrt_done;
  logic [sbe_pkg::ROOT_W-1:0] sqrt_root;
  logic [sbe_pkg::SQRT_IN_W-1:0] sqrt_opd;
  logic [sbe_pkg::ENERGY_W+1:0]  eng_sum;
  logic                      out_take, out_free;

  assign in_stall_o = state_q != ST_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_take   = out_vld_q && !out_stall_i;
  assign out_free   = !out_vld_q || !out_stall_i;

  // Sample count, hop phase and frame trigger; the count restarts before the
  // sample is stored when it opens a block, and sticks at its maximum.
  always_comb begin
    cnt_cur = block_start_i ? '0 : cnt_q;
    cnt_new = (cnt_cur == sbe_pkg::COUNT_MAX) ? cnt_cur : cnt_cur + COUNT_W'(1);
    if (cnt_new == COUNT_W'(FFT_SIZE)) begin
      ph_new = '0;
    end else if (cnt_cur != sbe_pkg::COUNT_MAX) begin
      ph_new = (ph_q == PH_W'(HOP_SIZE - 1)) ? '0 : ph_q + PH_W'(1);
    end else begin
      ph_new = ph_q;
    end
    fire = (cnt_new >= COUNT_W'(FFT_SIZE)) && (cnt_new <= COUNT_W'(BLOCK_SAMPLES))
           && (ph_new == '0);
  end

  // Butterfly addresses: group bits above the stage, offset j below it.
  always_comb begin
    jmask  = ~({(LOGN-1){1'b1}} << stg_q);
    jpart  = bf_q & jmask;
    ia     = {bf_q & ~jmask, 1'b0} | {1'b0, jpart};
    ib     = ia | (LOGN'(1) << stg_q);
    tw_sh  = STG_W'(LOGN - 1) - stg_q;
    tw_idx = jpart << tw_sh;
    wr     = COS_ROM[tw_idx*TW_W +: TW_W];
    wi     = -$signed(SIN_ROM[tw_idx*TW_W +: TW_W]);
    win_n  = WIN_ROM[n_q*WIN_W +: WIN_W];
  end

  // One shared complex-part multiplier and one squarer, each chosen by step.
  always_comb begin
    unique case (state_q)
      ST_LD_MUL: begin
        mul_a = WORK_W'($signed(smp_rdata));
        mul_b = $signed({1'b0, win_n});
      end
      ST_BF_M0: begin
        mul_a = wrk_rdata.re;
        mul_b = wr;
      end
      ST_BF_M1: begin
        mul_a = b_q.im;
        mul_b = wi;
      end
      ST_BF_M2: begin
        mul_a = b_q.re;
        mul_b = wi;
      end
      default: begin
        mul_a = b_q.im;
        mul_b = wr;
      end
    endcase
    mul_p   = mul_a * mul_b;
    sq_op   = (state_q == ST_BD_CAP) ? wrk_rdata.re : b_q.im;
    sq_p    = sq_op * sq_op;
    rnd_out = sbe_pkg::rnd_q15((state_q == ST_LD_WR) ? ACC_W'(prod_q) : diff_q);
  end

  always_comb begin
    lo_bin   = BIN_W'(sbe_pkg::BAND_LO[band_q]);
    hi_bin   = BIN_W'(sbe_pkg::BAND_HI[band_q]);
    hi_cap   = (hi_bin > BIN_W'(HALF - 1)) ? BIN_W'(HALF - 1) : hi_bin;
    sqrt_opd = sbe_pkg::SQRT_IN_W'(sqa_q) + sbe_pkg::SQRT_IN_W'(sqb_q);
    eng_sum  = (sbe_pkg::ENERGY_W+2)'(acc_q) + (sbe_pkg::ENERGY_W+2)'(sqrt_root);
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    frm_d     = frm_q;
    ph_d      = ph_q;
    base_d    = base_q;
    n_d       = n_q;
    stg_d     = stg_q;
    bf_d      = bf_q;
    band_d    = band_q;
    k_d       = k_q;
    kend_d    = kend_q;
    acc_d     = acc_q;
    a_d       = a_q;
    b_d       = b_q;
    prod_d    = prod_q;
    sum_d     = sum_q;
    diff_d    = diff_q;
    tr_d      = tr_q;
    ti_d      = ti_q;
    sqa_d     = sqa_q;
    sqb_d     = sqb_q;
    out_vld_d = out_take ? 1'b0 : out_vld_q;
    oband_d   = oband_q;
    ofrm_d    = ofrm_q;
    oeng_d    = oeng_q;
    olast_d   = olast_q;
    smp_we    = 1'b0;
    smp_raddr = base_q + n_q;
    wrk_we    = 1'b0;
    wrk_waddr = ia;
    wrk_wdata = '0;
    wrk_raddr = ia;
    sqrt_start = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          smp_we = 1'b1;
          cnt_d  = cnt_new;
          ph_d   = ph_new;
          if (block_start_i) frm_d = '0;
          if (fire) begin
            base_d  = cnt_new[LOGN-1:0];
            n_d     = '0;
            state_d = ST_LD_RD;
          end
        end
      end
      ST_LD_RD: state_d = ST_LD_MUL;
      ST_LD_MUL: begin
        prod_d  = mul_p;
        state_d = ST_LD_WR;
      end
      ST_LD_WR: begin
        // store windowed sample at its bit-reversed place, imaginary part zero
        wrk_we    = 1'b1;
        wrk_waddr = bit_rev(n_q);
        wrk_wdata = '{re: WORK_W'(rnd_out), im: '0};
        n_d       = n_q + LOGN'(1);
        if (n_q == '1) begin
          stg_d   = '0;
          bf_d    = '0;
          state_d = ST_BF_RDA;
        end else begin
          state_d = ST_LD_RD;
        end
      end
      ST_BF_RDA: state_d = ST_BF_RDB;
      ST_BF_RDB: begin
        wrk_raddr = ib;
        a_d       = wrk_rdata;
        state_d   = ST_BF_M0;
      end
      ST_BF_M0: begin
        b_d     = wrk_rdata;
        prod_d  = mul_p;
        state_d = ST_BF_M1;
      end
      ST_BF_M1: begin
        sum_d   = ACC_W'(prod_q);
        prod_d  = mul_p;
        state_d = ST_BF_M2;
      end
      ST_BF_M2: begin
        diff_d  = sum_q - ACC_W'(prod_q);
        prod_d  = mul_p;
        state_d = ST_BF_M3;
      end
      ST_BF_M3: begin
        tr_d    = WORK_W'(rnd_out);
        sum_d   = ACC_W'(prod_q);
        prod_d  = mul_p;
        state_d = ST_BF_M4;
      end
      ST_BF_M4: begin
        diff_d  = sum_q + ACC_W'(prod_q);
        state_d = ST_BF_M5;
      end
      ST_BF_M5: begin
        ti_d    = WORK_W'(rnd_out);
        state_d = ST_BF_WA;
      end
      ST_BF_WA: begin
        wrk_we    = 1'b1;
        wrk_waddr = ia;
        wrk_wdata = '{re: a_q.re + tr_q, im: a_q.im + ti_q};
        state_d   = ST_BF_WB;
      end
      ST_BF_WB: begin
        wrk_we    = 1'b1;
        wrk_waddr = ib;
        wrk_wdata = '{re: a_q.re - tr_q, im: a_q.im - ti_q};
        bf_d      = bf_q + (LOGN-1)'(1);
        state_d   = ST_BF_RDA;
        if (bf_q == '1) begin
          if (stg_q == STG_W'(LOGN - 1)) begin
            band_d  = '0;
            state_d = ST_BD_INIT;
          end else begin
            stg_d = stg_q + STG_W'(1);
          end
        end
      end
      ST_BD_INIT: begin
        k_d     = lo_bin;
        kend_d  = hi_cap;
        acc_d   = '0;
        // a band lying wholly above the half spectrum sums to zero
        state_d = (lo_bin > hi_cap) ? ST_EMIT : ST_BD_RD;
      end
      ST_BD_RD: begin
        wrk_raddr = k_q[LOGN-1:0];
        state_d   = ST_BD_CAP;
      end
      ST_BD_CAP: begin
        b_d     = wrk_rdata;
        sqa_d   = sq_p;
        state_d = ST_BD_SQ2;
      end
      ST_BD_SQ2: begin
        sqb_d   = sq_p;
        state_d = ST_BD_ROOT;
      end
      ST_BD_ROOT: begin
        sqrt_start = 1'b1;
        state_d    = ST_BD_WAIT;
      end
      ST_BD_WAIT: begin
        if (sqrt_done) begin
          acc_d = (eng_sum > (sbe_pkg::ENERGY_W+2)'(sbe_pkg::ENERGY_MAX))
                  ? sbe_pkg::ENERGY_MAX : sbe_pkg::ENERGY_W'(eng_sum);
          if (k_q == kend_q) begin
            state_d = ST_EMIT;
          end else begin
            k_d     = k_q + BIN_W'(1);
            state_d = ST_BD_RD;
          end
        end
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (out_free) begin
          out_vld_d = 1'b1;
          oband_d   = band_q;
          ofrm_d    = frm_q;
          oeng_d    = acc_q;
          olast_d   = band_q == sbe_pkg::BAND_W'(NB - 1);
          if (band_q == sbe_pkg::BAND_W'(NB - 1)) begin
            frm_d   = frm_q + sbe_pkg::FRAME_W'(1);
            state_d = ST_IDLE;
          end else begin
            band_d  = band_q + sbe_pkg::BAND_W'(1);
            state_d = ST_BD_INIT;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      frm_q     <= '0;
      ph_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      frm_q     <= frm_d;
      ph_q      <= ph_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q  <= base_d;
    n_q     <= n_d;
    stg_q   <= stg_d;
    bf_q    <= bf_d;
    band_q  <= band_d;
    k_q     <= k_d;
    kend_q  <= kend_d;
    acc_q   <= acc_d;
    a_q     <= a_d;
    b_q     <= b_d;
    prod_q  <= prod_d;
    sum_q   <= sum_d;
    diff_q  <= diff_d;
    tr_q    <= tr_d;
    ti_q    <= ti_d;
    sqa_q   <= sqa_d;
    sqb_q   <= sqb_d;
    oband_q <= oband_d;
    ofrm_q  <= ofrm_d;
    oeng_q  <= oeng_d;
    olast_q <= olast_d;
  end

  // Sample ring and in-place transform store
  sbe_ram #(
    .WIDTH (sbe_pkg::SAMPLE_W),
    .DEPTH (FFT_SIZE)
  ) u_smp_ram (
    .clk_i   (clk_i),
    .we_i    (smp_we),
    .waddr_i (cnt_cur[LOGN-1:0]),
    .wdata_i (sample_i),
    .raddr_i (smp_raddr),
    .rdata_o (smp_rdata)
  );

  sbe_ram #(
    .WIDTH (2 * sbe_pkg::WORK_W),
    .DEPTH (FFT_SIZE)
  ) u_wrk_ram (
    .clk_i   (clk_i),
    .we_i    (wrk_we),
    .waddr_i (wrk_waddr),
    .wdata_i (wrk_wdata),
    .raddr_i (wrk_raddr),
    .rdata_o (wrk_rdata)
  );

  sbe_isqrt #(
    .IN_W (sbe_pkg::SQRT_IN_W)
  ) u_isqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sqrt_start),
    .operand_i (sqrt_opd),
    .done_o    (sqrt_done),
    .root_o    (sqrt_root)
  );

  assign out_valid_o   = out_vld_q;
  assign band_index_o  = oband_q;
  assign frame_index_o = ofrm_q;
  assign band_energy_o = oeng_q;
  assign last_band_o   = olast_q;

  // Assertions
  a_last_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_band_o |-> band_index_o == sbe_pkg::BAND_W'(NB - 1))
    else $error("last band flag on a band other than the final one");

  a_band_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> band_index_o <= sbe_pkg::BAND_W'(NB - 1))
    else $error("band index beyond the band count");

  a_root_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> state_q == ST_BD_WAIT)
    else $error("square root finished outside the magnitude wait");

endmodule
